@@ sv/krq_pkg.sv @@
// Package for the keyed request queue.
// Holds operation, status and sequencer state types and the fixed field widths.
// No dependencies.
package krq_pkg;

    localparam int FUNC_W   = 2;
    localparam int ID_W     = 16;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ = 2'd0,
        FN_POP = 2'd1,
        FN_CHK = 2'd2,
        FN_NOP = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

@@ sv/krq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module krq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/krq_match.sv @@
// Shared compare unit of the keyed request queue.
// Compares one stored entry against the key, on the pair or on the destination only.
// Depends on nothing but its parameter.
module krq_match #(
    parameter int KW = 16
) (
    input  logic [2*KW-1:0] i_entry,
    input  logic [KW-1:0]   i_key_src,
    input  logic [KW-1:0]   i_key_dst,
    input  logic            i_dest_only,
    output logic            o_match
);

    logic dst_eq;
    logic src_eq;

    assign dst_eq  = (i_entry[KW-1:0] == i_key_dst);
    assign src_eq  = (i_entry[2*KW-1:KW] == i_key_src);
    assign o_match = dst_eq && (i_dest_only || src_eq);

endmodule

@@ sv/keyed_request_queue.sv @@
// Keyed request queue: arrival-ordered queue of (source, destination) pairs.
// An operation other than a no-op scans the stored entries in order until a hit or the last entry;
// a pop then moves each younger entry down one slot. One transaction at a time.
// The rate is set by the single compare unit and the one read port of the entry RAM.
// Synchronous active-low reset empties the queue and clears the handshake;
// entry RAM contents are not cleared and need no clearing pass.
module keyed_request_queue #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [krq_pkg::FUNC_W-1:0]      i_func,
    input  logic [krq_pkg::ID_W-1:0]        i_source_id,
    input  logic [krq_pkg::ID_W-1:0]        i_dest_id,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [krq_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_hit,
    output logic [krq_pkg::ID_W-1:0]        o_popped_source,
    output logic [krq_pkg::ID_W-1:0]        o_popped_dest
);

    import krq_pkg::*;

    localparam int KW = (ID_BITS < ID_W) ? ID_BITS : ID_W;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state            r_state, n_state;
    t_func             r_func, n_func;
    logic [KW-1:0]     r_src, n_src;
    logic [KW-1:0]     r_dst, n_dst;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_found, n_found;
    logic [2*KW-1:0]   r_pop_entry, n_pop_entry;

    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic              r_hit, n_hit;
    logic [KW-1:0]     r_psrc, n_psrc;
    logic [KW-1:0]     r_pdst, n_pdst;

    logic              in_acc;
    logic              load;
    logic              match;
    logic [2*KW-1:0]   rdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [2*KW-1:0]   ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [CW:0]       idx_p1;
    logic [CW:0]       idx_p2;
    logic [CW:0]       count_x;

    assign in_acc  = i_valid && !o_stall;
    assign load    = (r_state == S_DONE) && (!r_out_valid || !i_stall);
    assign idx_p1  = {1'b0, r_idx} + (CW+1)'(1);
    assign idx_p2  = {1'b0, r_idx} + (CW+1)'(2);
    assign count_x = {1'b0, r_count};

    krq_ram #(
        .WIDTH (2*KW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    krq_match #(
        .KW (KW)
    ) u_match (
        .i_entry     (rdata),
        .i_key_src   (r_src),
        .i_key_dst   (r_dst),
        .i_dest_only (r_func == FN_POP),
        .o_match     (match)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (t_func'(i_func) != FN_NOP && r_count != '0) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = (r_func == FN_POP && idx_p1 < count_x) ? S_SHIFT : S_DONE;
                end else if (idx_p1 == count_x) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (idx_p2 == count_x) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_func      = r_func;
        n_src       = r_src;
        n_dst       = r_dst;
        n_count     = r_count;
        n_idx       = r_idx;
        n_found     = r_found;
        n_pop_entry = r_pop_entry;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_hit       = r_hit;
        n_psrc      = r_psrc;
        n_pdst      = r_pdst;
        ram_we      = 1'b0;
        ram_waddr   = r_idx[AW-1:0];
        ram_wdata   = rdata;
        ram_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func  = t_func'(i_func);
                    n_src   = i_source_id[KW-1:0];
                    n_dst   = i_dest_id[KW-1:0];
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            S_SCAN: begin
                ram_raddr = idx_p1[AW-1:0];
                if (match) begin
                    n_found     = 1'b1;
                    n_pop_entry = rdata;
                end else if (idx_p1 != count_x) begin
                    n_idx = idx_p1[CW-1:0];
                end
            end
            S_SHIFT: begin
                ram_raddr = idx_p2[AW-1:0];
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = rdata;
                n_idx     = idx_p1[CW-1:0];
            end
            S_DONE: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_hit       = 1'b0;
                    n_psrc      = '0;
                    n_pdst      = '0;
                    unique case (r_func)
                        FN_ENQ: begin
                            if (r_found) begin
                                n_status = ST_DUP;
                            end else if (count_x >= (CW+1)'(DEPTH)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = {r_src, r_dst};
                                n_count   = r_count + CW'(1);
                            end
                        end
                        FN_POP: begin
                            if (r_found) begin
                                n_hit   = 1'b1;
                                n_psrc  = r_pop_entry[2*KW-1:KW];
                                n_pdst  = r_pop_entry[KW-1:0];
                                n_count = r_count - CW'(1);
                            end else begin
                                n_status = ST_NOMATCH;
                            end
                        end
                        FN_CHK: begin
                            if (r_found) begin
                                n_hit = 1'b1;
                            end else begin
                                n_status = ST_NOMATCH;
                            end
                        end
                        FN_NOP: begin
                            n_status = ST_OK;
                        end
                        default: n_status = ST_OK;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_pop_entry <= n_pop_entry;
        r_status    <= n_status;
        r_hit       <= n_hit;
        r_psrc      <= n_psrc;
        r_pdst      <= n_pdst;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_hit           = r_hit;
    assign o_popped_source = ID_W'(r_psrc);
    assign o_popped_dest   = ID_W'(r_pdst);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_x <= (CW+1)'(DEPTH))
        else $error("entry count above capacity");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < count_x))
        else $error("scan index beyond valid entries");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SCAN) |-> !ram_we)
        else $error("entry write outside shift or completion");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded without completion");

    a_shift_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_func == FN_POP && r_found))
        else $error("shift without a popped entry");
`endif

endmodule
